// ===== rtl/core/twg_pkg.sv =====
// Shared types, codes and constant-table helpers for the table waveform generator.
`default_nettype none
package twg_pkg;

   localparam int PCT_W    = 7;
   localparam int DAC_W    = 8;
   localparam int WIN_W    = 20;
   localparam int PERIOD_W = 20;

   localparam logic [PERIOD_W-1:0] PERIOD_NUM = 20'd1000000;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN = 20'd50;

   // queue operation codes; the button operations equal their button number
   localparam logic [2:0] OP_SHAPE  = 3'd0;
   localparam logic [2:0] OP_AMP    = 3'd1;
   localparam logic [2:0] OP_FREQ   = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_IGNORE = 3'd4;

   localparam logic       CMD_TICK     = 1'b0;
   localparam logic [1:0] BTN_SHAPE    = 2'd0;
   localparam logic [1:0] BTN_AMP      = 2'd1;
   localparam logic [1:0] BTN_FREQ     = 2'd2;
   localparam logic       KIND_SAMPLE  = 1'b0;
   localparam logic       KIND_BUTTON  = 1'b1;

   localparam logic [2:0] REG_DEBOUNCE = 3'd0;
   localparam logic [2:0] REG_AMP_MIN  = 3'd1;
   localparam logic [2:0] REG_AMP_MAX  = 3'd2;
   localparam logic [2:0] REG_AMP_STEP = 3'd3;
   localparam logic [2:0] REG_FRQ_MIN  = 3'd4;
   localparam logic [2:0] REG_FRQ_MAX  = 3'd5;
   localparam logic [2:0] REG_FRQ_STEP = 3'd6;

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef struct packed {
      logic [WIN_W-1:0] debounce_window_us;
      logic [PCT_W-1:0] amplitude_min_pct;
      logic [PCT_W-1:0] amplitude_max_pct;
      logic [PCT_W-1:0] amplitude_step_pct;
      logic [PCT_W-1:0] frequency_min_hz;
      logic [PCT_W-1:0] frequency_max_hz;
      logic [PCT_W-1:0] frequency_step_hz;
   } cfg_type;

   typedef struct packed {
      logic [2:0] op;
      logic       still;
   } q_ctrl_type;

   // shift-subtract quotient of unsigned operands; elaboration only
   function automatic longint unsigned quo_u64(longint unsigned a, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      int              b;
      q = 64'd0;
      r = 64'd0;
      for (b = 63; b >= 0; b--) begin
         r = {r[62:0], a[b]};
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   // sin (odd) or cos of x in Q30, 0 <= x < pi/2; elaboration only
   function automatic longint taylor_q30(longint x, bit odd);
      longint x2;
      longint term;
      longint sum;
      longint n;
      int     k;
      x2   = (x * x) >>> 30;
      term = odd ? x : Q30_ONE;
      sum  = term;
      n    = odd ? 64'sd2 : 64'sd1;
      for (k = 0; k < 12; k++) begin
         term = (term * x2) >>> 30;
         term = signed'(quo_u64(unsigned'(term), unsigned'(n * (n + 1))));
         sum  = ((k % 2) == 1) ? sum + term : sum - term;
         n    = n + 2;
      end
      return sum;
   endfunction

   function automatic logic [7:0] sine_code(longint x, int quad);
      longint s;
      longint num;
      case (quad % 4)
         0: s = taylor_q30(x, 1'b1);
         1: s = taylor_q30(x, 1'b0);
         2: s = -taylor_q30(x, 1'b1);
         default: s = -taylor_q30(x, 1'b0);
      endcase
      if (s > Q30_ONE) s = Q30_ONE;
      if (s < -Q30_ONE) s = -Q30_ONE;
      num = (64'sd255 * (Q30_ONE + s)) >>> 31;
      return (num > 255) ? 8'd255 : num[7:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/twg_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface twg_req_if #(parameter int TIME_BITS = 40);
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [1:0]           button;
   logic [TIME_BITS-1:0] event_time_us;
   logic                 still_pressed;
   logic [TIME_BITS-1:0] confirm_time_us;

   modport source(output valid, command, button, event_time_us, still_pressed,
                  confirm_time_us, input ready);
   modport sink(input valid, command, button, event_time_us, still_pressed,
                confirm_time_us, output ready);
endinterface

interface twg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [twg_pkg::DAC_W-1:0]     dac_value;
   logic                          accepted;
   logic [1:0]                    shape_now;
   logic [twg_pkg::PCT_W-1:0]     amplitude_now;
   logic [twg_pkg::PCT_W-1:0]     frequency_now;
   logic [twg_pkg::PERIOD_W-1:0]  sample_period_us;
   logic                          period_changed;

   modport source(output valid, kind, dac_value, accepted, shape_now, amplitude_now,
                  frequency_now, sample_period_us, period_changed, input ready);
   modport sink(input valid, kind, dac_value, accepted, shape_now, amplitude_now,
                frequency_now, sample_period_us, period_changed, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/twg_front.sv =====
// Front end: accepts request beats, classifies them and queues them two deep.
`default_nettype none
module twg_front #(
   parameter int TIME_BITS = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   twg_req_if.sink                   req,
   output logic                      q_valid,
   input  wire logic                 q_pop,
   output twg_pkg::q_ctrl_type       q_ctrl,
   output logic [TIME_BITS-1:0]      q_event_time,
   output logic [TIME_BITS-1:0]      q_confirm_time
);
   import twg_pkg::*;

   localparam logic [1:0] QDEPTH = 2'd2;

   q_ctrl_type           ctrl_w;
   q_ctrl_type           ctrl_q_ff [2];
   logic [TIME_BITS-1:0] ev_q_ff [2];
   logic [TIME_BITS-1:0] cf_q_ff [2];
   logic                 rd_ptr_ff, rd_ptr_in;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push;

   always_comb begin
      ctrl_w.still = req.still_pressed;
      if (req.command == CMD_TICK) begin
         ctrl_w.op = OP_TICK;
      end else begin
         case (req.button)
            BTN_SHAPE: ctrl_w.op = OP_SHAPE;
            BTN_AMP:   ctrl_w.op = OP_AMP;
            BTN_FREQ:  ctrl_w.op = OP_FREQ;
            default:   ctrl_w.op = OP_IGNORE;
         endcase
      end
   end

   assign req.ready = (count_ff != QDEPTH);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);

   assign q_ctrl         = ctrl_q_ff[rd_ptr_ff];
   assign q_event_time   = ev_q_ff[rd_ptr_ff];
   assign q_confirm_time = cf_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) count_in = count_ff + 2'd1;
      if (!push && q_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_q_ff[wr_ptr_ff] <= ctrl_w;
         ev_q_ff[wr_ptr_ff]   <= req.event_time_us;
         cf_q_ff[wr_ptr_ff]   <= req.confirm_time_us;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QDEPTH) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0) else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not grow on push");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/twg_div.sv =====
// Restoring divider: 1000000 / divisor, one quotient bit per cycle.
`default_nettype none
module twg_div #(
   parameter int DIV_W = 15
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [DIV_W-1:0]             divisor,
   output logic                              done,
   output logic [twg_pkg::PERIOD_W-1:0]      quotient
);
   import twg_pkg::*;

   localparam int CNT_W = $clog2(PERIOD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    dsr_ff, dsr_in;
   logic [PERIOD_W-1:0] num_ff, num_in;
   logic [PERIOD_W-1:0] quo_ff, quo_in;
   logic [DIV_W:0]      trial;
   logic [DIV_W:0]      diff;
   logic                fits;

   assign trial = {rem_ff, num_ff[PERIOD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PERIOD_W - 1);
         rem_in  = '0;
         dsr_in  = divisor;
         num_in  = PERIOD_NUM;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[PERIOD_W-2:0], fits};
         num_in = {num_ff[PERIOD_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/core/twg_back.sv =====
// Back end: sequencer that runs sample scaling, debounce, stepping and period math.
`default_nettype none
module twg_back #(
   parameter int SAMPLES   = 100,
   parameter int TIME_BITS = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire twg_pkg::cfg_type     cfg,
   input  wire logic                 q_valid,
   output logic                      q_pop,
   input  wire twg_pkg::q_ctrl_type  q_ctrl,
   input  wire logic [TIME_BITS-1:0] q_event_time,
   input  wire logic [TIME_BITS-1:0] q_confirm_time,
   twg_rsp_if.source                 rsp
);
   import twg_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES);
   localparam int DIV_W = $clog2(127 * SAMPLES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_SCALE = 3'd2;
   localparam logic [2:0] S_DEB   = 3'd3;
   localparam logic [2:0] S_PER   = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   // waveform tables: sine, triangle, sawtooth, square
   logic [7:0] rom_w [4][SAMPLES];

   for (genvar g = 0; g < SAMPLES; g++) begin : g_rom
      localparam int         Q4   = 4 * g;
      localparam int         QUAD = Q4 / SAMPLES;
      localparam int         REM  = Q4 % SAMPLES;
      localparam longint     XQ   = HALF_PI_Q30 * REM / SAMPLES;
      localparam logic [7:0] SINE = sine_code(XQ, QUAD);
      localparam logic [7:0] TRI  = (2 * g < SAMPLES) ? 8'((510 * g) / SAMPLES)
                                  : 8'((255 * (2 * SAMPLES - 2 * g)) / SAMPLES);
      localparam logic [7:0] SAW  = 8'((255 * g) / SAMPLES);
      localparam logic [7:0] SQR  = (2 * g < SAMPLES) ? 8'd255 : 8'd0;
      assign rom_w[0][g] = SINE;
      assign rom_w[1][g] = TRI;
      assign rom_w[2][g] = SAW;
      assign rom_w[3][g] = SQR;
   end

   logic [2:0]           state_ff, state_in;
   q_ctrl_type           cur_ff, cur_in;
   logic [TIME_BITS-1:0] ev_ff, ev_in;
   logic [TIME_BITS-1:0] conf_ff, conf_in;
   logic [13:0]          mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [DAC_W-1:0]     dac_ff, dac_in;
   logic                 acc_ff, acc_in;
   logic [PERIOD_W-1:0]  per_ff, per_in;
   logic                 chg_ff, chg_in;
   logic                 kind_ff, kind_in;

   logic [1:0]           shape_ff, shape_in;
   logic [PCT_W-1:0]     amp_ff, amp_in;
   logic [PCT_W-1:0]     freq_ff, freq_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [TIME_BITS-1:0] last_ff [3];
   logic [TIME_BITS-1:0] last_in [3];

   logic                 out_valid_ff, out_valid_in;
   logic                 out_kind_ff, out_acc_ff, out_chg_ff;
   logic [DAC_W-1:0]     out_dac_ff;
   logic [1:0]           out_shape_ff;
   logic [PCT_W-1:0]     out_amp_ff, out_freq_ff;
   logic [PERIOD_W-1:0]  out_per_ff;
   logic                 out_load;

   logic signed [8:0]    centered_w;
   logic signed [16:0]   prod_w;
   logic [16:0]          prod_abs_w;
   logic [26:0]          recip_w;
   logic [7:0]           quot_w;
   logic [8:0]           up_w;
   logic [TIME_BITS:0]   since_w;
   logic                 too_soon_w;
   logic [1:0]           btn_w;
   logic [PCT_W:0]       amp_sum_w;
   logic [PCT_W:0]       frq_sum_w;

   logic                 div_start;
   logic [DIV_W-1:0]     div_divisor;
   logic                 div_done;
   logic [PERIOD_W-1:0]  div_quotient;

   twg_div #(.DIV_W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign div_divisor = DIV_W'(freq_ff) * DIV_W'(SAMPLES);
   assign out_load    = !out_valid_ff || rsp.ready;

   // signed sample about mid-scale, times amplitude percent
   assign centered_w = $signed({1'b0, rom_w[shape_ff][idx_ff]}) - 9'sd128;
   assign prod_w     = centered_w * $signed({1'b0, amp_ff});
   assign prod_abs_w = prod_w[16] ? 17'(-prod_w) : 17'(prod_w);
   // divide by 100: multiply by 5243 / 2^19, exact below 2^14
   assign recip_w    = 27'(mag_ff) * 27'd5243;
   assign quot_w     = recip_w[26:19];
   assign up_w       = 9'd128 + 9'(quot_w);

   assign btn_w      = cur_ff.op[1:0];
   assign since_w    = {1'b0, ev_ff} - {1'b0, last_ff[btn_w]};
   assign too_soon_w = since_w[TIME_BITS] ||
                       (since_w[TIME_BITS-1:0] < TIME_BITS'(cfg.debounce_window_us));
   assign amp_sum_w  = {1'b0, amp_ff} + {1'b0, cfg.amplitude_step_pct};
   assign frq_sum_w  = {1'b0, freq_ff} + {1'b0, cfg.frequency_step_hz};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      ev_in        = ev_ff;
      conf_in      = conf_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      dac_in       = dac_ff;
      acc_in       = acc_ff;
      per_in       = per_ff;
      chg_in       = chg_ff;
      kind_in      = kind_ff;
      shape_in     = shape_ff;
      amp_in       = amp_ff;
      freq_in      = freq_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      q_pop        = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cur_in  = q_ctrl;
               ev_in   = q_event_time;
               conf_in = q_confirm_time;
               dac_in  = '0;
               acc_in  = 1'b0;
               per_in  = '0;
               chg_in  = 1'b0;
               kind_in = (q_ctrl.op == OP_TICK) ? KIND_SAMPLE : KIND_BUTTON;
               case (q_ctrl.op)
                  OP_TICK:   state_in = S_MUL;
                  OP_SHAPE,
                  OP_AMP,
                  OP_FREQ:   state_in = S_DEB;
                  default:   state_in = S_OUT;
               endcase
            end
         end
         S_MUL: begin
            mag_in   = prod_abs_w[13:0];
            neg_in   = prod_w[16];
            idx_in   = (idx_ff == IDX_W'(SAMPLES - 1)) ? '0 : idx_ff + IDX_W'(1);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            // clamp to the DAC range
            if (neg_ff) begin
               dac_in = (quot_w > 8'd128) ? 8'd0 : 8'd128 - quot_w;
            end else begin
               dac_in = up_w[8] ? 8'd255 : up_w[7:0];
            end
            state_in = S_OUT;
         end
         S_DEB: begin
            state_in = S_OUT;
            if (!too_soon_w && cur_ff.still) begin
               acc_in         = 1'b1;
               last_in[btn_w] = conf_ff;
               case (cur_ff.op)
                  OP_SHAPE: shape_in = shape_ff + 2'd1;
                  OP_AMP: begin
                     amp_in = (amp_sum_w > {1'b0, cfg.amplitude_max_pct})
                              ? cfg.amplitude_min_pct : amp_sum_w[PCT_W-1:0];
                  end
                  default: begin
                     freq_in  = (frq_sum_w > {1'b0, cfg.frequency_max_hz})
                                ? cfg.frequency_min_hz : frq_sum_w[PCT_W-1:0];
                     chg_in   = 1'b1;
                     state_in = S_PER;
                  end
               endcase
            end
         end
         S_PER: begin
            if (freq_ff == '0) begin
               per_in   = PERIOD_NUM;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               per_in   = (div_quotient < PERIOD_MIN) ? PERIOD_MIN : div_quotient;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         shape_ff     <= 2'd0;
         amp_ff       <= 7'd100;
         freq_ff      <= 7'd10;
         idx_ff       <= '0;
         last_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         shape_ff     <= shape_in;
         amp_ff       <= amp_in;
         freq_ff      <= freq_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      ev_ff   <= ev_in;
      conf_ff <= conf_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      dac_ff  <= dac_in;
      acc_ff  <= acc_in;
      per_ff  <= per_in;
      chg_ff  <= chg_in;
      kind_ff <= kind_in;
      if (state_ff == S_OUT && out_load) begin
         out_kind_ff  <= kind_ff;
         out_dac_ff   <= dac_ff;
         out_acc_ff   <= acc_ff;
         out_shape_ff <= shape_ff;
         out_amp_ff   <= amp_ff;
         out_freq_ff  <= freq_ff;
         out_per_ff   <= per_ff;
         out_chg_ff   <= chg_ff;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.kind             = out_kind_ff;
   assign rsp.dac_value        = out_dac_ff;
   assign rsp.accepted         = out_acc_ff;
   assign rsp.shape_now        = out_shape_ff;
   assign rsp.amplitude_now    = out_amp_ff;
   assign rsp.frequency_now    = out_freq_ff;
   assign rsp.sample_period_us = out_per_ff;
   assign rsp.period_changed   = out_chg_ff;

`ifndef NO_ASSERTIONS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE) && q_valid) else $error("pop outside idle");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider finished unexpectedly");
   a_chg_button: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_chg_ff) |-> (out_kind_ff == KIND_BUTTON) && out_acc_ff)
      else $error("period change without accepted press");
   a_sample_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_SAMPLE) |-> !out_acc_ff && out_per_ff == '0)
      else $error("sample beat carries button fields");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/table_waveform_generator_top.sv =====
// Top level: register file, front-end queue and back-end sequencer.
// Sequence: a sample tick passes the MUL, SCALE and OUT states; a shape or
// amplitude press passes DEB and OUT; an accepted frequency press also passes PER
// and DIV, where the one-bit-per-cycle period divider runs its 20 steps.
// The sequencer pops the next item only after OUT has loaded the output register.
// Reset (synchronous, active high) loads register defaults and the waveform state.
`default_nettype none
module table_waveform_generator_top #(
   parameter int SAMPLES   = 100,
   parameter int TIME_BITS = 40
) (
   input  wire logic        clock,
   input  wire logic        reset,
   twg_req_if.sink          req,
   twg_rsp_if.source        rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import twg_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic [2:0]           reg_idx;
   logic                 wr_en;
   logic                 q_valid;
   logic                 q_pop;
   q_ctrl_type           q_ctrl;
   logic [TIME_BITS-1:0] q_event_time;
   logic [TIME_BITS-1:0] q_confirm_time;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DEBOUNCE: cfg_in.debounce_window_us = pwdata[WIN_W-1:0];
            REG_AMP_MIN:  cfg_in.amplitude_min_pct  = pwdata[PCT_W-1:0];
            REG_AMP_MAX:  cfg_in.amplitude_max_pct  = pwdata[PCT_W-1:0];
            REG_AMP_STEP: cfg_in.amplitude_step_pct = pwdata[PCT_W-1:0];
            REG_FRQ_MIN:  cfg_in.frequency_min_hz   = pwdata[PCT_W-1:0];
            REG_FRQ_MAX:  cfg_in.frequency_max_hz   = pwdata[PCT_W-1:0];
            REG_FRQ_STEP: cfg_in.frequency_step_hz  = pwdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE: prdata = 32'(cfg_ff.debounce_window_us);
         REG_AMP_MIN:  prdata = 32'(cfg_ff.amplitude_min_pct);
         REG_AMP_MAX:  prdata = 32'(cfg_ff.amplitude_max_pct);
         REG_AMP_STEP: prdata = 32'(cfg_ff.amplitude_step_pct);
         REG_FRQ_MIN:  prdata = 32'(cfg_ff.frequency_min_hz);
         REG_FRQ_MAX:  prdata = 32'(cfg_ff.frequency_max_hz);
         REG_FRQ_STEP: prdata = 32'(cfg_ff.frequency_step_hz);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_window_us <= 20'd200000;
         cfg_ff.amplitude_min_pct  <= 7'd20;
         cfg_ff.amplitude_max_pct  <= 7'd100;
         cfg_ff.amplitude_step_pct <= 7'd10;
         cfg_ff.frequency_min_hz   <= 7'd1;
         cfg_ff.frequency_max_hz   <= 7'd100;
         cfg_ff.frequency_step_hz  <= 7'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   twg_front #(.TIME_BITS(TIME_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_ctrl         (q_ctrl),
      .q_event_time   (q_event_time),
      .q_confirm_time (q_confirm_time)
   );

   twg_back #(.SAMPLES(SAMPLES), .TIME_BITS(TIME_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_ctrl         (q_ctrl),
      .q_event_time   (q_event_time),
      .q_confirm_time (q_confirm_time),
      .rsp            (rsp)
   );
endmodule
`default_nettype wire
